// ===== design/fmsd_pkg.sv =====
// fmsd_pkg: shared types and constants for the multi-server dispatch block
// depends on nothing; used by fmsd_ctrl, fmsd_dp and fifo_multi_server_dispatch
package fmsd_pkg;

  // default sizing
  localparam int DEF_MAX_WINDOWS = 8;
  localparam int DEF_QUEUE_DEPTH = 64;

  // field widths
  localparam int TW  = 16;
  localparam int RW  = 17;
  localparam int CFW = 4;

  localparam logic [CFW-1:0] WINDOW_COUNT_RESET = 4'd4;

  // input function codes
  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_ENQ,
    S_HEAD,
    S_SCAN,
    S_COUNT,
    S_REPORT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic enq;
    logic step;
    logic countdown;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic take;
    logic out_free;
  } sts_t;

endpackage

// ===== design/fmsd_ctrl.sv =====
// fmsd_ctrl: sequencing state machine for enqueue and tick transactions
// depends on fmsd_pkg; drives fmsd_dp through cmd_t, reads sts_t
module fmsd_ctrl import fmsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        state_next = sts.is_tick ? S_HEAD : S_ENQ;
      end
      S_ENQ: begin
        cmd.enq    = 1'b1;
        state_next = S_REPORT;
      end
      // wait state for the registered fifo head read to land
      S_HEAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_COUNT;
        end else begin
          cmd.step = 1'b1;
          if (sts.take) begin
            state_next = S_HEAD;
          end
        end
      end
      S_COUNT: begin
        cmd.countdown = 1'b1;
        state_next    = S_REPORT;
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fmsd_dp.sv =====
// fmsd_dp: job fifo memory, window counters, sim clock and result register
// depends on fmsd_pkg; commanded by fmsd_ctrl
module fmsd_dp import fmsd_pkg::*; #(
  parameter int MAX_WINDOWS = DEF_MAX_WINDOWS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  logic            func,
  input  logic [TW-1:0]   arrival_tick,
  input  logic [TW-1:0]   service_time,
  input  logic            cfg_write,
  input  logic [CFW-1:0]  window_count,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [TW-1:0]   tick_clock,
  output logic [7:0]      assigned_mask,
  output logic [7:0]      busy_mask,
  output logic [3:0]      free_windows,
  output logic [6:0]      queue_level,
  output logic            all_done,
  output logic            dropped
);

  localparam int NW   = $clog2(MAX_WINDOWS + 1);
  localparam int IW   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW   = (NW > CFW) ? NW : CFW;
  localparam int MW8  = (MAX_WINDOWS > 8) ? MAX_WINDOWS : 8;
  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW   = (CNTW > 7) ? CNTW : 7;
  localparam int FW   = (NW > 4) ? NW : 4;

  logic [CFW-1:0]    win_cfg;
  logic [NW-1:0]     n_use;
  logic [CW-1:0]     cfg_ext;

  logic [2*TW-1:0]   mem [QUEUE_DEPTH];
  logic [2*TW-1:0]   rd_data;
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  logic [CNTW-1:0]   count;
  logic              full;

  logic [RW-1:0]     rem [MAX_WINDOWS];
  logic [TW-1:0]     sim_clock;

  logic              func_q;
  logic [TW-1:0]     arr_q;
  logic [TW-1:0]     svc_q;
  logic [TW-1:0]     clk_item;
  logic [MW8-1:0]    assigned;
  logic              drop_q;

  logic [NW-1:0]     sc;
  logic [IW-1:0]     idx;
  logic              take;

  logic [MW8-1:0]    busy_vec;
  logic [NW-1:0]     idle_cnt;
  logic              any_busy;
  logic [FW-1:0]     idle_ext;
  logic [LW-1:0]     lvl_ext;

  // window count register
  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg <= WINDOW_COUNT_RESET;
    end else if (cfg_write) begin
      win_cfg <= window_count;
    end
  end

  // windows in use, zero acts as one and large values clamp
  always_comb begin
    cfg_ext = CW'(win_cfg);
    if (cfg_ext == '0) begin
      n_use = NW'(1);
    end else if (cfg_ext > CW'(MAX_WINDOWS)) begin
      n_use = NW'(MAX_WINDOWS);
    end else begin
      n_use = cfg_ext[NW-1:0];
    end
  end

  // input capture and per-item flags
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_q   <= func;
      arr_q    <= arrival_tick;
      svc_q    <= service_time;
      clk_item <= sim_clock;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assigned <= '0;
      drop_q   <= 1'b0;
      sc       <= '0;
    end else if (cmd.latch_in) begin
      assigned <= '0;
      drop_q   <= 1'b0;
      sc       <= '0;
    end else begin
      if (cmd.enq) begin
        drop_q <= full;
      end
      if (cmd.step) begin
        sc <= sc + NW'(1);
        if (take) begin
          assigned[idx] <= 1'b1;
        end
      end
    end
  end

  // job memory, head read registered every cycle
  always_ff @(posedge clk) begin
    if (cmd.enq && !full) begin
      mem[wr_ptr] <= {arr_q, svc_q};
    end
    rd_data <= mem[rd_ptr];
  end

  assign full = (count == CNTW'(QUEUE_DEPTH));
  assign idx  = sc[IW-1:0];

  // current window takes the head job
  assign take = (rem[idx] == '0) && (count != '0) && (rd_data[2*TW-1:TW] <= clk_item);

  // fifo pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else if (cmd.enq && !full) begin
      wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      count  <= count + CNTW'(1);
    end else if (cmd.step && take) begin
      rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      count  <= count - CNTW'(1);
    end
  end

  // window counters: load on assignment, count down together
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        rem[i] <= '0;
      end
    end else if (cmd.step && take) begin
      rem[idx] <= {1'b0, rd_data[TW-1:0]} + RW'(1);
    end else if (cmd.countdown) begin
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        if (rem[i] != '0) begin
          rem[i] <= rem[i] - RW'(1);
        end
      end
    end
  end

  // sim clock, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      sim_clock <= '0;
    end else if (cmd.countdown && (sim_clock != '1)) begin
      sim_clock <= sim_clock + TW'(1);
    end
  end

  // status summary of the windows
  always_comb begin
    busy_vec = '0;
    idle_cnt = '0;
    any_busy = 1'b0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      if (rem[i] != '0) begin
        busy_vec[i] = 1'b1;
        any_busy    = 1'b1;
      end else if (NW'(i) < n_use) begin
        idle_cnt = idle_cnt + NW'(1);
      end
    end
    idle_ext = FW'(idle_cnt);
    lvl_ext  = LW'(count);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tick_clock    <= clk_item;
      assigned_mask <= assigned[7:0];
      busy_mask     <= busy_vec[7:0];
      free_windows  <= (idle_ext > FW'(15)) ? 4'd15 : idle_ext[3:0];
      queue_level   <= (lvl_ext > LW'(127)) ? 7'd127 : lvl_ext[6:0];
      all_done      <= (count == '0) && !any_busy;
      dropped       <= drop_q;
    end
  end

  // status to controller
  always_comb begin
    sts.is_tick   = (func_q == FUNC_TICK);
    sts.scan_done = (sc == n_use);
    sts.take      = take;
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule

// ===== design/fifo_multi_server_dispatch.sv =====
// fifo_multi_server_dispatch: top level of the multi-server queue dispatcher
// depends on fmsd_pkg, fmsd_ctrl, fmsd_dp
//
//   channel | signals                                  | direction
//   input   | in_valid, in_stall, func, arrival_tick,  | in (stall out)
//           | service_time                             |
//   output  | out_valid, out_stall, tick_clock, ...    | out (stall in)
//   config  | cfg_valid, cfg_ready, window_count       | in (ready out)
//
// an enqueue runs S_DISP, S_ENQ, S_REPORT to the result register; a tick
// runs S_DISP, S_HEAD, S_SCAN, S_COUNT, S_REPORT, n windows in use scanned
// one per cycle, each pop via S_HEAD for the registered fifo head read.
// one transaction is in work at a time; the result register frees the core
// so the next transaction is accepted while a result waits under out_stall.
// rst is synchronous: all windows idle, fifo empty, clock zero, count 4.
module fifo_multi_server_dispatch import fmsd_pkg::*; #(
  parameter int MAX_WINDOWS = DEF_MAX_WINDOWS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           func,
  input  logic [TW-1:0]  arrival_tick,
  input  logic [TW-1:0]  service_time,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [TW-1:0]  tick_clock,
  output logic [7:0]     assigned_mask,
  output logic [7:0]     busy_mask,
  output logic [3:0]     free_windows,
  output logic [6:0]     queue_level,
  output logic           all_done,
  output logic           dropped,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [CFW-1:0] window_count
);

  cmd_t cmd;
  sts_t sts;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  fmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fmsd_dp #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .func          (func),
    .arrival_tick  (arrival_tick),
    .service_time  (service_time),
    .cfg_write     (cfg_valid && cfg_ready),
    .window_count  (window_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tick_clock    (tick_clock),
    .assigned_mask (assigned_mask),
    .busy_mask     (busy_mask),
    .free_windows  (free_windows),
    .queue_level   (queue_level),
    .all_done      (all_done),
    .dropped       (dropped)
  );

endmodule

// ===== bench/fmsd_checker.sv =====
// fmsd_checker: watches the input, result and config channels of the dispatcher,
// predicts every result from its own copy of the queue state and compares them
// depends on fmsd_pkg; instantiated beside the block by tb_fifo_multi_server_dispatch
module fmsd_checker import fmsd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic           func,
  input  logic [TW-1:0]  arrival_tick,
  input  logic [TW-1:0]  service_time,
  input  logic           out_valid,
  input  logic           out_stall,
  input  logic [TW-1:0]  tick_clock,
  input  logic [7:0]     assigned_mask,
  input  logic [7:0]     busy_mask,
  input  logic [3:0]     free_windows,
  input  logic [6:0]     queue_level,
  input  logic           all_done,
  input  logic           dropped,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [CFW-1:0] window_count,
  output int             errors,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TW-1:0] arrival;
    logic [TW-1:0] service;
  } job_t;

  typedef struct packed {
    logic [TW-1:0] tick_clock;
    logic [7:0]    assigned_mask;
    logic [7:0]    busy_mask;
    logic [3:0]    free_windows;
    logic [6:0]    queue_level;
    logic          all_done;
    logic          dropped;
  } dispatch_report_t;

  // shadow of the dispatcher state
  job_t             waiting_jobs[$];
  logic [RW-1:0]    window_left [DEF_MAX_WINDOWS];
  logic [TW-1:0]    disp_clock;
  logic [CFW-1:0]   windows_cfg;
  dispatch_report_t pending_reports[$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t fmsd_checker: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // advance the shadow state by one transaction and build its report
  function automatic dispatch_report_t dispatch_step(input logic f,
                                                      input logic [TW-1:0] arr,
                                                      input logic [TW-1:0] svc);
    dispatch_report_t r;
    int               n;
    int               idle;
    logic [7:0]       taken;
    logic [7:0]       busy;
    job_t             head;
    r = '0;
    taken = '0;
    busy = '0;
    idle = 0;
    r.tick_clock = disp_clock;
    // zero acts as one window, anything above the maximum as the maximum
    if (windows_cfg == 0) n = 1;
    else if (windows_cfg > DEF_MAX_WINDOWS) n = DEF_MAX_WINDOWS;
    else n = int'(windows_cfg);

    if (f == FUNC_ENQUEUE) begin
      if (waiting_jobs.size() >= DEF_QUEUE_DEPTH) r.dropped = 1'b1;
      else waiting_jobs.push_back(job_t'{arrival: arr, service: svc});
    end else begin
      // idle windows in use take the head job once it has arrived
      for (int i = 0; i < n; i++) begin
        if (window_left[i] == '0 && waiting_jobs.size() != 0) begin
          head = waiting_jobs[0];
          if (head.arrival <= disp_clock) begin
            window_left[i] = {1'b0, head.service} + 1'b1;
            void'(waiting_jobs.pop_front());
            taken[i] = 1'b1;
          end
        end
      end
      // every busy window counts down, windows beyond the count included
      for (int i = 0; i < DEF_MAX_WINDOWS; i++) begin
        if (window_left[i] != '0) window_left[i] = window_left[i] - 1'b1;
      end
      if (disp_clock != '1) disp_clock = disp_clock + 1'b1;
    end

    // status after the transaction
    for (int i = 0; i < DEF_MAX_WINDOWS; i++) begin
      if (window_left[i] != '0) busy[i] = 1'b1;
      else if (i < n) idle++;
    end
    r.assigned_mask = taken;
    r.busy_mask = busy;
    r.free_windows = (idle > 15) ? 4'd15 : 4'(idle);
    r.queue_level = (waiting_jobs.size() > 127) ? 7'd127 : 7'(waiting_jobs.size());
    r.all_done = (waiting_jobs.size() == 0) && (busy == '0);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    dispatch_report_t got;
    dispatch_report_t want;
    if (rst) begin
      waiting_jobs.delete();
      pending_reports.delete();
      foreach (window_left[i]) window_left[i] = '0;
      disp_clock = '0;
      windows_cfg = WINDOW_COUNT_RESET;
    end else begin
      // result transaction: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        got.tick_clock = tick_clock;
        got.assigned_mask = assigned_mask;
        got.busy_mask = busy_mask;
        got.free_windows = free_windows;
        got.queue_level = queue_level;
        got.all_done = all_done;
        got.dropped = dropped;
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, tick_clock %0d",
                                    tick_clock));
        end else begin
          want = pending_reports.pop_front();
          check_field("tick_clock", got.tick_clock, want.tick_clock);
          check_field("assigned_mask", got.assigned_mask, want.assigned_mask);
          check_field("busy_mask", got.busy_mask, want.busy_mask);
          check_field("free_windows", got.free_windows, want.free_windows);
          check_field("queue_level", got.queue_level, want.queue_level);
          check_field("all_done", got.all_done, want.all_done);
          check_field("dropped", got.dropped, want.dropped);
        end
      end
      // config transaction
      if (cfg_valid && cfg_ready) windows_cfg = window_count;
      // input transaction
      if (in_valid && !in_stall) begin
        pending_reports.push_back(dispatch_step(func, arrival_tick, service_time));
      end
    end
    outstanding = pending_reports.size();
  end

endmodule

// ===== bench/tb_fifo_multi_server_dispatch.sv =====
// tb_fifo_multi_server_dispatch: stimulus and verdict for the multi-server dispatcher
// depends on fmsd_pkg, fifo_multi_server_dispatch and fmsd_checker
// directed jobs, random job/tick segments under several window counts, then extreme jobs
module tb_fifo_multi_server_dispatch;
  import fmsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           func = FUNC_ENQUEUE;
  logic [TW-1:0]  arrival_tick = '0;
  logic [TW-1:0]  service_time = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [TW-1:0]  tick_clock;
  logic [7:0]     assigned_mask;
  logic [7:0]     busy_mask;
  logic [3:0]     free_windows;
  logic [6:0]     queue_level;
  logic           all_done;
  logic           dropped;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [CFW-1:0] window_count = WINDOW_COUNT_RESET;
  int             errors;
  int             outstanding;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len = 0;
  int sim_ticks = 0;

  int seg_windows [10] = '{1, 8, 15, 0, 9, 2, 6, 3, 5, 7};
  int seg_enq_pct [10] = '{80, 40, 70, 35, 85, 40, 60, 45, 75, 50};

  fifo_multi_server_dispatch i_dut (.*);
  fmsd_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("tb_fifo_multi_server_dispatch NOT OK");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin : rx_side
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // offer one transaction, with a random gap first, and wait for it to be taken
  task automatic send_item(input logic f, input logic [TW-1:0] a, input logic [TW-1:0] s);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    func <= f;
    arrival_tick <= a;
    service_time <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == FUNC_TICK) sim_ticks++;
  endtask

  // every transaction gives a result, so once none is pending the core is idle;
  // the wait after that covers the result register handing back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_windows(input logic [CFW-1:0] v);
    cfg_valid <= 1'b1;
    window_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random job or tick; arrivals mostly near the current clock so the head moves
  task automatic send_random(input int enq_pct);
    logic [TW-1:0] now_clk;
    logic [TW-1:0] arr;
    logic [TW-1:0] svc;
    now_clk = (sim_ticks > 65535) ? 16'hFFFF : TW'(sim_ticks);
    if ($urandom_range(99) < enq_pct) begin
      case ($urandom_range(9))
        0:       arr = TW'($urandom_range(now_clk));
        1:       arr = now_clk + TW'($urandom_range(20, 60));
        default: arr = now_clk + TW'($urandom_range(0, 3));
      endcase
      case ($urandom_range(9))
        0:       svc = '0;
        1:       svc = TW'($urandom_range(30, 150));
        default: svc = TW'($urandom_range(1, 10));
      endcase
      send_item(FUNC_ENQUEUE, arr, svc);
    end else begin
      send_item(FUNC_TICK, TW'($urandom), TW'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tick, zero service, head not yet arrived, window count changes
    tx_idle_pct = 23;
    rx_idle_pct = 66;
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_ENQUEUE, 16'd0, 16'd0);
    send_item(FUNC_ENQUEUE, 16'd0, 16'd40);
    send_item(FUNC_ENQUEUE, 16'd0, 16'd5);
    send_item(FUNC_ENQUEUE, 16'd3, 16'd2);
    repeat (3) send_item(FUNC_TICK, '0, '0);
    // lower the count while upper windows are still serving
    settle();
    set_windows(4'd1);
    send_item(FUNC_ENQUEUE, 16'd0, 16'd1);
    repeat (2) send_item(FUNC_TICK, '0, '0);
    // above the maximum acts as the maximum
    settle();
    set_windows(4'd15);
    send_item(FUNC_ENQUEUE, 16'd0, 16'd3);
    repeat (2) send_item(FUNC_TICK, '0, '0);
    // zero acts as one window
    settle();
    set_windows(4'd0);
    send_item(FUNC_ENQUEUE, 16'd0, 16'd2);
    repeat (2) send_item(FUNC_TICK, '0, '0);

    // random segments, each under its own window count and job mix
    for (int seg = 0; seg < 10; seg++) begin
      settle();
      if (seg < 4) begin
        tx_idle_pct = 23;
        rx_idle_pct = 66;
      end else if (seg < 8) begin
        tx_idle_pct = 66;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_windows(CFW'(seg_windows[seg]));
      // long receiver hold-off while jobs keep coming, to back up the input
      if (seg == 2) hold_len = 400;
      repeat (175) send_random(seg_enq_pct[seg]);
    end

    // extreme arrivals and service times
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_windows(4'd3);
    send_item(FUNC_ENQUEUE, 16'h5555, 16'hAAAA);
    send_item(FUNC_ENQUEUE, 16'hAAAA, 16'h5555);
    send_item(FUNC_ENQUEUE, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_ENQUEUE, 16'hFFFF, 16'h0000);
    repeat (8) send_item(FUNC_TICK, TW'($urandom), TW'($urandom));
    send_item(FUNC_ENQUEUE, 16'hFFFF, 16'h0001);
    repeat (3) send_item(FUNC_TICK, '0, '0);

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fifo_multi_server_dispatch OK");
    end else begin
      $display("tb_fifo_multi_server_dispatch NOT OK");
    end
    $finish;
  end

endmodule
